FILE: rtl/rcdp_pkg.sv
// rcdp_pkg: shared widths, codes and control struct for the residual codebook
// dot product core. No dependencies.
package rcdp_pkg;

	localparam int VAL_W  = 16;
	localparam int CODE_W = 8;
	localparam int WGT_W  = 18;
	localparam int PROD_W = 34;
	localparam int ACC_W  = 48;
	localparam int OUT_W  = 32;

	localparam logic       REQ_LOAD = 1'b0;
	localparam logic       REQ_TERM = 1'b1;

	localparam logic       REG_STAGE_COUNT = 1'b0;
	localparam logic [1:0] STAGE_COUNT_RST = 2'd2;
	localparam logic [1:0] STAGES_THREE    = 2'd3;

	typedef struct packed {
		logic p01;
		logic p2;
		logic wt;
		logic mul;
		logic acc;
		logic clr;
		logic use3;
	} mac_ctl_t;

endpackage

FILE: rtl/residual_codebook_dot_product_core.sv
// Residual codebook dot product core: sequencer, register port, output register.
// Depends on rcdp_pkg, rcdp_codebook and rcdp_mac.
// A load item is taken in the idle state. A term item walks P1, P2, W, M and A with
// in_stall high; a last term then waits in F on out_stall and registers the result.
// The sequencer walks two codebook read steps, weight round, multiply and accumulate.
// Reset clears stage_count to 2, the accumulator and all control; codebook is unset.
module residual_codebook_dot_product_core #(
	parameter int CODEBOOK_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [7:0]          entry_index,
	input  logic signed [15:0]  entry_value,
	input  logic signed [15:0]  x_value,
	input  logic [7:0]          code0,
	input  logic [7:0]          code1,
	input  logic [7:0]          code2,
	input  logic signed [15:0]  scale0,
	input  logic signed [15:0]  scale1,
	input  logic signed [15:0]  scale2,
	input  logic signed [31:0]  bias,
	input  logic                last_term,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  out_value
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_P1   = 3'd1;
	localparam logic [2:0] ST_P2   = 3'd2;
	localparam logic [2:0] ST_W    = 3'd3;
	localparam logic [2:0] ST_M    = 3'd4;
	localparam logic [2:0] ST_A    = 3'd5;
	localparam logic [2:0] ST_F    = 3'd6;

	logic [2:0]         state_q;
	logic [1:0]         stage_count_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic signed [15:0] x_q, scale0_q, scale1_q, scale2_q;
	logic signed [31:0] bias_q;
	logic [7:0]         code2_q;
	logic               last_q;

	logic               in_acc, cfg_wr, fin_load;
	logic [7:0]         raddr_a;
	logic signed [15:0] e_a, e_b;
	logic signed [31:0] result;
	rcdp_pkg::mac_ctl_t ctl;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == rcdp_pkg::REG_STAGE_COUNT);
	assign prdata   = (paddr[2] == rcdp_pkg::REG_STAGE_COUNT) ? {30'd0, stage_count_q} : 32'd0;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign fin_load  = (state_q == ST_F) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

	assign raddr_a = (state_q == ST_IDLE) ? code0 : code2_q;

	always_comb begin
		ctl      = '0;
		ctl.p01  = (state_q == ST_P1);
		ctl.p2   = (state_q == ST_P2);
		ctl.wt   = (state_q == ST_W);
		ctl.mul  = (state_q == ST_M);
		ctl.acc  = (state_q == ST_A);
		ctl.clr  = fin_load;
		ctl.use3 = (stage_count_q == rcdp_pkg::STAGES_THREE);
	end

	rcdp_codebook #(
		.ENTRIES(CODEBOOK_ENTRIES)
	) u_codebook (
		.clk     (clk),
		.we      (in_acc && (req_type == rcdp_pkg::REQ_LOAD)),
		.waddr   (entry_index),
		.wdata   (entry_value),
		.raddr_a (raddr_a),
		.raddr_b (code1),
		.rdata_a (e_a),
		.rdata_b (e_b)
	);

	rcdp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.e_a     (e_a),
		.e_b     (e_b),
		.scale0  (scale0_q),
		.scale1  (scale1_q),
		.scale2  (scale2_q),
		.x_value (x_q),
		.bias    (bias_q),
		.result  (result)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q      <= x_value;
			scale0_q <= scale0;
			scale1_q <= scale1;
			scale2_q <= scale2;
			bias_q   <= bias;
			code2_q  <= code2;
			last_q   <= last_term;
		end
		if (fin_load) begin
			out_value_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			stage_count_q <= rcdp_pkg::STAGE_COUNT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				stage_count_q <= pwdata[1:0];
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == rcdp_pkg::REQ_TERM)) begin
						state_q <= ST_P1;
					end
				end
				ST_P1:   state_q <= ST_P2;
				ST_P2:   state_q <= ST_W;
				ST_W:    state_q <= ST_M;
				ST_M:    state_q <= ST_A;
				ST_A:    state_q <= last_q ? ST_F : ST_IDLE;
				ST_F: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/rcdp_codebook.sv
// rcdp_codebook: codebook memory, one write port, two registered read ports.
// Depends on rcdp_pkg.
module rcdp_codebook #(
	parameter int ENTRIES = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [rcdp_pkg::CODE_W-1:0]            waddr,
	input  logic signed [rcdp_pkg::VAL_W-1:0]      wdata,
	input  logic [rcdp_pkg::CODE_W-1:0]            raddr_a,
	input  logic [rcdp_pkg::CODE_W-1:0]            raddr_b,
	output logic signed [rcdp_pkg::VAL_W-1:0]      rdata_a,
	output logic signed [rcdp_pkg::VAL_W-1:0]      rdata_b
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [rcdp_pkg::CODE_W:0] LIMIT = (rcdp_pkg::CODE_W+1)'(ENTRIES);

	logic signed [rcdp_pkg::VAL_W-1:0] mem [ENTRIES];
	logic signed [rcdp_pkg::VAL_W-1:0] rd_a_q, rd_b_q;
	logic                              ok_a_q, ok_b_q;
	logic                              w_ok, ok_a, ok_b;

	assign w_ok = {1'b0, waddr}   < LIMIT;
	assign ok_a = {1'b0, raddr_a} < LIMIT;
	assign ok_b = {1'b0, raddr_b} < LIMIT;

	always_ff @(posedge clk) begin
		if (we && w_ok) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		rd_a_q <= mem[raddr_a[AW-1:0]];
		rd_b_q <= mem[raddr_b[AW-1:0]];
		ok_a_q <= ok_a;
		ok_b_q <= ok_b;
	end

	assign rdata_a = ok_a_q ? rd_a_q : '0;
	assign rdata_b = ok_b_q ? rd_b_q : '0;

endmodule

FILE: rtl/rcdp_mac.sv
// rcdp_mac: weight rebuild, rounding, multiply-accumulate and final rounding.
// Depends on rcdp_pkg.
module rcdp_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rcdp_pkg::mac_ctl_t                 ctl,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  e_a,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  e_b,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  scale0,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  scale1,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  scale2,
	input  logic signed [rcdp_pkg::VAL_W-1:0]  x_value,
	input  logic signed [rcdp_pkg::OUT_W-1:0]  bias,
	output logic signed [rcdp_pkg::OUT_W-1:0]  result
);
	logic signed [31:0] p0_s1, p1_s1, p2_s2;
	logic signed [32:0] s01_s2;
	logic signed [33:0] wsum, wadd, wsh;
	logic signed [rcdp_pkg::WGT_W-1:0]  w_q;
	logic signed [rcdp_pkg::PROD_W-1:0] prod_q;
	logic signed [rcdp_pkg::ACC_W-1:0]  acc_q;
	logic signed [rcdp_pkg::ACC_W:0]    asum, a2;
	logic signed [36:0]                 sh37;
	logic signed [37:0]                 tot;

	assign wsum = $signed({s01_s2[32], s01_s2}) + $signed({{2{p2_s2[31]}}, p2_s2});
	assign wadd = wsum + 34'sd2048;
	assign wsh  = wadd >>> 12;

	assign asum = $signed({acc_q[rcdp_pkg::ACC_W-1], acc_q})
		+ $signed({{(rcdp_pkg::ACC_W+1-rcdp_pkg::PROD_W){prod_q[rcdp_pkg::PROD_W-1]}}, prod_q});

	assign a2   = $signed({acc_q[rcdp_pkg::ACC_W-1], acc_q}) + 49'sd2048;
	assign sh37 = a2[48:12];
	assign tot  = $signed({sh37[36], sh37}) + $signed({{6{bias[31]}}, bias});

	always_comb begin
		if (tot > 38'sd2147483647) begin
			result = 32'sh7FFFFFFF;
		end else if (tot < -38'sd2147483648) begin
			result = 32'sh80000000;
		end else begin
			result = tot[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.p01) begin
			p0_s1 <= e_a * scale0;
			p1_s1 <= e_b * scale1;
		end
		if (ctl.p2) begin
			s01_s2 <= $signed({p0_s1[31], p0_s1}) + $signed({p1_s1[31], p1_s1});
			p2_s2  <= ctl.use3 ? e_a * scale2 : 32'sd0;
		end
		if (ctl.wt) begin
			if (wsh > 34'sd131071) begin
				w_q <= 18'sh1FFFF;
			end else if (wsh < -34'sd131072) begin
				w_q <= 18'sh20000;
			end else begin
				w_q <= wsh[rcdp_pkg::WGT_W-1:0];
			end
		end
		if (ctl.mul) begin
			prod_q <= x_value * w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			if (asum[rcdp_pkg::ACC_W] != asum[rcdp_pkg::ACC_W-1]) begin
				acc_q <= asum[rcdp_pkg::ACC_W] ? {1'b1, {(rcdp_pkg::ACC_W-1){1'b0}}}
					: {1'b0, {(rcdp_pkg::ACC_W-1){1'b1}}};
			end else begin
				acc_q <= asum[rcdp_pkg::ACC_W-1:0];
			end
		end
	end

endmodule

FILE: bench/residual_codebook_dot_product_core_test.sv
// Self-checking bench for residual_codebook_dot_product_core: randomized load and term
// items with an in-bench predictor of the codebook, weight rebuild and 48-bit accumulator.
// Depends on rcdp_pkg and the core RTL only.
module residual_codebook_dot_product_core_test;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  entry_index;
		logic [15:0] entry_value;
		logic [15:0] x_value;
		logic [7:0]  code0;
		logic [7:0]  code1;
		logic [7:0]  code2;
		logic [15:0] scale0;
		logic [15:0] scale1;
		logic [15:0] scale2;
		logic [31:0] bias;
		logic        last_term;
	} rc_item_t;

	localparam logic [2:0] STAGE_ADDR = 3'(4 * int'(rcdp_pkg::REG_STAGE_COUNT));
	localparam longint W_TOP   = 131071;
	localparam longint W_BOT   = -131072;
	localparam longint ACC_TOP = 64'sh0000_7fff_ffff_ffff;
	localparam longint ACC_BOT = -ACC_TOP - 1;
	localparam longint O_TOP   = 64'sd2147483647;
	localparam longint O_BOT   = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_value;
	rc_item_t cur_item = '0;

	rc_item_t pending_q[$];
	logic [31:0] sums_due[$];
	int written_idx[$];

	logic [15:0] cb_copy [256];
	longint acc_copy = 0;
	logic [1:0] stages_copy = rcdp_pkg::STAGE_COUNT_RST;

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic hold_out = 1'b0;
	logic squeeze = 1'b0;
	logic calm = 1'b0;
	logic stall_now;
	int send_gap = 0;
	int take_gap = 0;
	int fails = 0;

	residual_codebook_dot_product_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(cur_item.req_type),
		.entry_index(cur_item.entry_index),
		.entry_value(cur_item.entry_value),
		.x_value(cur_item.x_value),
		.code0(cur_item.code0),
		.code1(cur_item.code1),
		.code2(cur_item.code2),
		.scale0(cur_item.scale0),
		.scale1(cur_item.scale1),
		.scale2(cur_item.scale2),
		.bias(cur_item.bias),
		.last_term(cur_item.last_term),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_value(out_value)
	);

	always #2 clk = ~clk;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void run_dot_step(input rc_item_t it);
		longint wsum;
		longint wgt;
		longint total;
		if (it.req_type == rcdp_pkg::REQ_LOAD) begin
			cb_copy[it.entry_index] = it.entry_value;
			return;
		end
		wsum = longint'($signed(cb_copy[it.code0])) * longint'($signed(it.scale0))
			+ longint'($signed(cb_copy[it.code1])) * longint'($signed(it.scale1));
		if (stages_copy == rcdp_pkg::STAGES_THREE)
			wsum += longint'($signed(cb_copy[it.code2])) * longint'($signed(it.scale2));
		wgt = clamp((wsum + 2048) >>> 12, W_BOT, W_TOP);
		acc_copy = clamp(acc_copy + longint'($signed(it.x_value)) * wgt, ACC_BOT, ACC_TOP);
		if (it.last_term) begin
			total = acc_copy + longint'($signed(it.bias)) * 4096;
			total = clamp((total + 2048) >>> 12, O_BOT, O_TOP);
			sums_due.push_back(total[31:0]);
			acc_copy = 0;
		end
	endfunction

	task automatic flag_bad(input string what, input logic [31:0] want, input logic [31:0] got);
		fails++;
		if (fails <= 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
	endtask

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 16);
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'($signed(16'($urandom)));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_code();
		return 8'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
	endfunction

	// load: only index and value matter, the rest is junk
	task automatic push_load(input logic [7:0] idx, input logic [15:0] val, input logic last);
		rc_item_t it;
		it = {rcdp_pkg::REQ_LOAD, idx, val, 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 32'($urandom), last};
		written_idx.push_back(int'(idx));
		pending_q.push_back(it);
	endtask

	task automatic push_term(input logic [15:0] x, input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [31:0] b, input logic last);
		rc_item_t it;
		it = {rcdp_pkg::REQ_TERM, 8'($urandom), 16'($urandom), x, c0, c1, c2, s0, s1, s2, b,
			last};
		pending_q.push_back(it);
	endtask

	task automatic push_rand_term(input logic last);
		push_term(pick16(), pick_code(), pick_code(), pick_code(), pick16(), pick16(),
			pick16(), pick32(), last);
	endtask

	task automatic queue_random(input int count);
		int n;
		int len;
		int k;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					push_load(8'($urandom), pick16(), 1'($urandom));
				n += len;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						push_load(8'($urandom), pick16(), 1'($urandom));
						n++;
					end
					push_rand_term((k == len - 1) ? 1'b1 : ($urandom_range(0, 29) == 0));
					n++;
				end
			end
		end
	endtask

	task automatic reg_access(input logic wr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= STAGE_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			stages_copy = data[1:0];
		else if (prdata[1:0] !== stages_copy)
			flag_bad("stage_count read", {30'b0, stages_copy}, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_stages(input logic [1:0] n);
		reg_access(1'b1, {30'b0, n});
		reg_access(1'b0, '0);
	endtask

	// idle: queue empty, nothing in flight, then room for a trailing term
	task automatic drain();
		while (pending_q.size() != 0 || in_valid || sums_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (in_took || !in_valid)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				cur_item <= pending_q.pop_front();
				in_valid <= 1'b1;
				send_gap = draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_took)
			take_gap = draw_gap();
		stall_now = (take_gap > 0);
		if (stall_now)
			take_gap--;
		out_stall <= hold_out || stall_now;
	end

	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			run_dot_step(cur_item);
	end

	always @(posedge clk) begin
		out_took <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (sums_due.size() == 0)
				flag_bad("unexpected out_value", 'x, out_value);
			else if (out_value !== sums_due[0])
				flag_bad("out_value", sums_due.pop_front(), out_value);
			else
				void'(sums_due.pop_front());
		end
	end

	initial begin
		@(posedge clk);
		wait (squeeze);
		@(posedge clk);
		hold_out = 1'b1;
		repeat (400) @(posedge clk);
		hold_out = 1'b0;
	end

	initial begin
		#2000000;
		$display("residual_codebook_dot_product_core verification failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		reg_access(1'b0, '0);

		push_load(8'd0, 16'h8000, 1'b0);
		push_load(8'd255, 16'h7fff, 1'b0);
		push_load(8'd1, 16'h1000, 1'b0);
		push_load(8'd2, 16'hffff, 1'b0);
		push_load(8'd85, 16'haaaa, 1'b0);
		push_load(8'd170, 16'h5555, 1'b1);
		// weight saturation both ways, output saturation both ways
		push_term(16'h7fff, 8'd0, 8'd0, 8'd170, 16'h8000, 16'h8000, 16'h7fff, 32'd0, 1'b1);
		push_term(16'h7fff, 8'd255, 8'd255, 8'd0, 16'h7fff, 16'h7fff, 16'h8000,
			32'h7fff_ffff, 1'b1);
		push_term(16'h7fff, 8'd0, 8'd255, 8'd0, 16'h7fff, 16'h8000, 16'h0000,
			32'h8000_0000, 1'b1);
		push_term(16'h8000, 8'd0, 8'd255, 8'd85, 16'h7fff, 16'h8000, 16'h8000,
			32'h8000_0000, 1'b1);
		// rounding just past the half step, multi-term sum
		push_term(16'h1000, 8'd1, 8'd2, 8'd85, 16'h1000, 16'h0000, 16'h7fff, 32'd5, 1'b0);
		push_term(16'hffff, 8'd2, 8'd2, 8'd1, 16'h0001, 16'h0800, 16'h1000, 32'd7, 1'b0);
		push_term(16'h0003, 8'd1, 8'd170, 8'd2, 16'h0800, 16'h0001, 16'h0001,
			32'hffff_ffff, 1'b1);
		push_term(16'h0000, 8'd85, 8'd170, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff, 32'd0, 1'b1);
		drain();

		set_stages(rcdp_pkg::STAGES_THREE);
		push_term(16'h7fff, 8'd0, 8'd0, 8'd0, 16'h8000, 16'h8000, 16'h8000, 32'd0, 1'b1);
		push_term(16'h1000, 8'd1, 8'd2, 8'd85, 16'h1000, 16'h0800, 16'h7fff, 32'd1, 1'b0);
		push_term(16'h8000, 8'd170, 8'd1, 8'd255, 16'h0001, 16'hffff, 16'h8000,
			32'h7fff_ffff, 1'b1);
		queue_random(120);
		drain();

		set_stages(2'd0);
		queue_random(120);
		squeeze = 1'b1;
		drain();

		set_stages(2'd1);
		calm = 1'b1;
		queue_random(120);
		drain();

		set_stages(rcdp_pkg::STAGE_COUNT_RST);
		calm = 1'b0;
		queue_random(120);
		drain();

		set_stages(rcdp_pkg::STAGES_THREE);
		queue_random(120);
		drain();

		if (fails == 0)
			$display("residual_codebook_dot_product_core verification clean");
		else
			$display("residual_codebook_dot_product_core verification failed");
		$finish;
	end

endmodule
